[rtl/rprt_pkg.sv]
// ============================================================================
// rprt_pkg: shared definitions for the register pointer rename tracker
// Widths, codes and the structures passed between the front end, the back
// end and the configuration registers.
// ============================================================================
package rprt_pkg;

    localparam int PTR_W        = 7;
    localparam int SLOT_IN_W    = 6;
    localparam int IMM_W        = 32;
    localparam int STACK_W      = 64;
    localparam int APB_AW       = 4;
    localparam int APB_DW       = 64;
    localparam int OP_SLOTS_DEF = 64;
    localparam int Q_DEPTH      = 2;

    localparam logic [PTR_W-1:0] ZERO_DISTANCE = '0;

    localparam logic REQ_FETCH = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    localparam logic [1:0] STK_NONE = 2'd0;
    localparam logic [1:0] STK_IMM1 = 2'd1;
    localparam logic [1:0] STK_IMM2 = 2'd2;

    localparam logic REG_START_POINTER = 1'b0;
    localparam logic REG_START_STACK   = 1'b1;

    typedef enum logic {
        BK_RUN,
        BK_RESTORE
    } bk_state_t;

    typedef struct packed {
        logic                    is_flush;
        logic                    advance;
        logic                    is_rpinc;
        logic                    sp_add;
        logic [1:0]              stack_slot;
        logic signed [IMM_W-1:0] imm;
        logic                    src_a_used;
        logic                    src_b_used;
        logic [PTR_W-1:0]        dist_a;
        logic [PTR_W-1:0]        dist_b;
    } rprt_op_t;

    typedef struct packed {
        logic               load_ptr;
        logic               load_stack;
        logic [PTR_W-1:0]   ptr;
        logic [STACK_W-1:0] stack;
    } rprt_cfg_t;

    typedef struct packed {
        logic restoring;
    } rprt_status_t;

endpackage

[rtl/rprt_regs.sv]
// ============================================================================
// rprt_regs: configuration registers
// APB-style register file holding the start pointer and start stack values.
// A write also loads the matching live pointer in the back end.
// ============================================================================
module rprt_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rprt_pkg::APB_AW-1:0]  paddr,
    input  logic [rprt_pkg::APB_DW-1:0]  pwdata,
    output logic [rprt_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output rprt_pkg::rprt_cfg_t          cfg
);
    import rprt_pkg::*;

    logic [PTR_W-1:0]   start_ptr_reg;
    logic [STACK_W-1:0] start_stack_reg;
    logic               wr_en;
    logic               reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_ptr_reg   <= '0;
            start_stack_reg <= '0;
        end else if (wr_en) begin
            if (reg_idx == REG_START_POINTER) begin
                start_ptr_reg <= pwdata[PTR_W-1:0];
            end else begin
                start_stack_reg <= pwdata[STACK_W-1:0];
            end
        end
    end

    always_comb begin
        cfg.load_ptr   = wr_en && (reg_idx == REG_START_POINTER);
        cfg.load_stack = wr_en && (reg_idx == REG_START_STACK);
        cfg.ptr        = pwdata[PTR_W-1:0];
        cfg.stack      = pwdata[STACK_W-1:0];
        if (reg_idx == REG_START_POINTER) begin
            prdata = APB_DW'(start_ptr_reg);
        end else begin
            prdata = APB_DW'(start_stack_reg);
        end
    end

endmodule

[rtl/rprt_front.sv]
// ============================================================================
// rprt_front: request classification and op queue
// Decodes each incoming transaction into a compact op and holds it in a
// two-entry queue until the back end takes it.
// ============================================================================
module rprt_front #(
    parameter  int OP_SLOTS = rprt_pkg::OP_SLOTS_DEF,
    localparam int SLOT_W   = $clog2(OP_SLOTS)
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_req_type,
    input  logic [rprt_pkg::SLOT_IN_W-1:0]       s_op_slot,
    input  logic                                 s_is_rpinc,
    input  logic                                 s_is_sp_add,
    input  logic                                 s_is_sp_mem,
    input  logic                                 s_is_syscall_branch,
    input  logic                                 s_three_imms,
    input  logic signed [rprt_pkg::IMM_W-1:0]    s_immediate,
    input  logic [1:0]                           s_source_count,
    input  logic [rprt_pkg::PTR_W-1:0]           s_distance_a,
    input  logic [rprt_pkg::PTR_W-1:0]           s_distance_b,
    input  logic                                 pop,
    output logic                                 q_valid,
    output rprt_pkg::rprt_op_t                   q_op,
    output logic [SLOT_W-1:0]                    q_slot
);
    import rprt_pkg::*;

    localparam int LUT_N = 1 << SLOT_IN_W;
    localparam int Q_AW  = $clog2(Q_DEPTH);
    localparam int Q_CW  = $clog2(Q_DEPTH + 1);

    logic [SLOT_W-1:0] slot_lut [LUT_N];

    for (genvar i = 0; i < LUT_N; i++) begin : g_slot_lut
        assign slot_lut[i] = SLOT_W'(i % OP_SLOTS);
    end

    rprt_op_t          op_in;
    logic              push;
    rprt_op_t          fifo_op_reg   [Q_DEPTH];
    logic [SLOT_W-1:0] fifo_slot_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_next;
    logic [Q_CW-1:0]   count_reg;
    logic [Q_CW-1:0]   count_next;

    always_comb begin
        op_in.is_flush   = (s_req_type == REQ_FLUSH);
        op_in.advance    = !s_is_syscall_branch;
        op_in.is_rpinc   = s_is_rpinc;
        op_in.sp_add     = s_is_sp_add;
        op_in.imm        = s_immediate;
        op_in.dist_a     = s_distance_a;
        op_in.dist_b     = s_distance_b;
        op_in.src_a_used = (s_source_count != 2'd0) && (s_distance_a != ZERO_DISTANCE);
        op_in.src_b_used = s_source_count[1] && (s_distance_b != ZERO_DISTANCE);
        if (!s_is_syscall_branch && !s_is_sp_add && s_is_sp_mem) begin
            op_in.stack_slot = s_three_imms ? STK_IMM2 : STK_IMM1;
        end else begin
            op_in.stack_slot = STK_NONE;
        end
    end

    assign s_ready = (count_reg != Q_CW'(Q_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign q_op    = fifo_op_reg[rd_ptr_reg];
    assign q_slot  = fifo_slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + Q_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + Q_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + Q_CW'(push) - Q_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_op_reg[wr_ptr_reg]   <= op_in;
            fifo_slot_reg[wr_ptr_reg] <= slot_lut[s_op_slot];
        end
    end

endmodule

[rtl/rprt_back.sv]
// ============================================================================
// rprt_back: rename execution and pointer checkpoints
// Renames fetched ops against the live ring pointer, keeps the ring and stack
// pointers with their per-op checkpoints, and restores them on a flush.
// ============================================================================
module rprt_back #(
    parameter  int OP_SLOTS = rprt_pkg::OP_SLOTS_DEF,
    localparam int SLOT_W   = $clog2(OP_SLOTS)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_valid,
    input  rprt_pkg::rprt_op_t               q_op,
    input  logic [SLOT_W-1:0]                q_slot,
    output logic                             pop,
    input  rprt_pkg::rprt_cfg_t              cfg,
    output rprt_pkg::rprt_status_t           status,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [rprt_pkg::PTR_W-1:0]       m_dest_reg,
    output logic [rprt_pkg::PTR_W-1:0]       m_src_reg_a,
    output logic [rprt_pkg::PTR_W-1:0]       m_src_reg_b,
    output logic                             m_src_a_renamed,
    output logic                             m_src_b_renamed,
    output logic [1:0]                       m_stack_slot,
    output logic [rprt_pkg::STACK_W-1:0]     m_stack_value
);
    import rprt_pkg::*;

    bk_state_t          state_reg;
    bk_state_t          state_next;
    logic [PTR_W-1:0]   ptr_reg;
    logic [PTR_W-1:0]   ptr_next;
    logic [STACK_W-1:0] stack_reg;
    logic [STACK_W-1:0] stack_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [PTR_W-1:0]   dest_reg;
    logic [PTR_W-1:0]   dest_next;
    logic [PTR_W-1:0]   src_a_reg;
    logic [PTR_W-1:0]   src_a_next;
    logic [PTR_W-1:0]   src_b_reg;
    logic [PTR_W-1:0]   src_b_next;
    logic               ren_a_reg;
    logic               ren_a_next;
    logic               ren_b_reg;
    logic               ren_b_next;
    logic [1:0]         stk_slot_reg;
    logic [1:0]         stk_slot_next;
    logic [STACK_W-1:0] stk_val_reg;
    logic [STACK_W-1:0] stk_val_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [STACK_W-1:0] rd_stack_reg;
    logic [PTR_W-1:0]   ckpt_ptr_mem   [OP_SLOTS];
    logic [STACK_W-1:0] ckpt_stack_mem [OP_SLOTS];

    logic               out_free;
    logic               do_fetch;
    logic               do_flush;
    logic               restoring;
    logic [PTR_W-1:0]   ptr_step;
    logic [STACK_W-1:0] imm_ext;

    assign out_free  = !out_valid_reg || m_ready;
    assign restoring = (state_reg == BK_RESTORE);
    assign do_fetch  = pop && !q_op.is_flush;
    assign do_flush  = pop && q_op.is_flush;
    assign ptr_step  = q_op.is_rpinc ? q_op.imm[PTR_W-1:0] + PTR_W'(1) : PTR_W'(1);
    assign imm_ext   = {{(STACK_W - IMM_W){q_op.imm[IMM_W-1]}}, q_op.imm};

    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        case (state_reg)
            BK_RUN: begin
                if (q_valid && out_free) begin
                    pop = 1'b1;
                    if (q_op.is_flush) begin
                        state_next = BK_RESTORE;
                    end
                end
            end
            BK_RESTORE: begin
                state_next = BK_RUN;
            end
            default: begin
                state_next = BK_RUN;
            end
        endcase
    end

    always_comb begin
        ptr_next   = ptr_reg;
        stack_next = stack_reg;
        if (cfg.load_ptr) begin
            ptr_next = cfg.ptr;
        end else if (restoring) begin
            ptr_next = rd_ptr_reg;
        end else if (do_fetch && q_op.advance) begin
            ptr_next = ptr_reg + ptr_step;
        end
        if (cfg.load_stack) begin
            stack_next = cfg.stack;
        end else if (restoring) begin
            stack_next = rd_stack_reg;
        end else if (do_fetch && q_op.advance && q_op.sp_add) begin
            stack_next = stack_reg + imm_ext;
        end
    end

    always_comb begin
        dest_next     = '0;
        src_a_next    = '0;
        src_b_next    = '0;
        ren_a_next    = 1'b0;
        ren_b_next    = 1'b0;
        stk_slot_next = STK_NONE;
        stk_val_next  = '0;
        if (!q_op.is_flush) begin
            dest_next     = ptr_reg;
            ren_a_next    = q_op.src_a_used;
            ren_b_next    = q_op.src_b_used;
            src_a_next    = q_op.src_a_used ? ptr_reg - q_op.dist_a : '0;
            src_b_next    = q_op.src_b_used ? ptr_reg - q_op.dist_b : '0;
            stk_slot_next = q_op.stack_slot;
            stk_val_next  = (q_op.stack_slot != STK_NONE) ? stack_reg : '0;
        end
        if (pop) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_RUN;
            ptr_reg       <= '0;
            stack_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            stack_reg     <= stack_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            dest_reg     <= dest_next;
            src_a_reg    <= src_a_next;
            src_b_reg    <= src_b_next;
            ren_a_reg    <= ren_a_next;
            ren_b_reg    <= ren_b_next;
            stk_slot_reg <= stk_slot_next;
            stk_val_reg  <= stk_val_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_fetch) begin
            ckpt_ptr_mem[q_slot]   <= ptr_reg;
            ckpt_stack_mem[q_slot] <= stack_reg;
        end
        if (do_flush) begin
            rd_ptr_reg   <= ckpt_ptr_mem[q_slot];
            rd_stack_reg <= ckpt_stack_mem[q_slot];
        end
    end

    assign status.restoring = restoring;
    assign m_valid          = out_valid_reg;
    assign m_dest_reg       = dest_reg;
    assign m_src_reg_a      = src_a_reg;
    assign m_src_reg_b      = src_b_reg;
    assign m_src_a_renamed  = ren_a_reg;
    assign m_src_b_renamed  = ren_b_reg;
    assign m_stack_slot     = stk_slot_reg;
    assign m_stack_value    = stk_val_reg;

endmodule

[rtl/register_pointer_rename_tracker.sv]
// ============================================================================
// register_pointer_rename_tracker: ring pointer rename and checkpoint tracker
// Renames distance-addressed operands against a ring pointer, tracks the
// stack pointer and restores both from per-op checkpoints on a flush.
//
//   Port group   Direction   Role
//   s_*          in          fetch or flush transaction
//   m_*          out         renamed op result, one per transaction
//   p*           in/out      APB-style start value registers
//
// Fetches sustain one per cycle while the result port does not stall. On a
// flush the checkpoint memory read is registered and the pointers load in
// the cycle after it; no new transaction is taken while they restore.
// An accepted input is held in a queue entry, then in the output register.
// Reset clears the queue, pointers and output valid; checkpoints need no
// clearing pass. A stalled result port holds the output register, and the
// two-entry queue absorbs input until it fills.
// ============================================================================
module register_pointer_rename_tracker #(
    parameter int OP_SLOTS = rprt_pkg::OP_SLOTS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rprt_pkg::APB_AW-1:0]       paddr,
    input  logic [rprt_pkg::APB_DW-1:0]       pwdata,
    output logic [rprt_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_req_type,
    input  logic [rprt_pkg::SLOT_IN_W-1:0]    s_op_slot,
    input  logic                              s_is_rpinc,
    input  logic                              s_is_sp_add,
    input  logic                              s_is_sp_mem,
    input  logic                              s_is_syscall_branch,
    input  logic                              s_three_imms,
    input  logic signed [rprt_pkg::IMM_W-1:0] s_immediate,
    input  logic [1:0]                        s_source_count,
    input  logic [rprt_pkg::PTR_W-1:0]        s_distance_a,
    input  logic [rprt_pkg::PTR_W-1:0]        s_distance_b,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rprt_pkg::PTR_W-1:0]        m_dest_reg,
    output logic [rprt_pkg::PTR_W-1:0]        m_src_reg_a,
    output logic [rprt_pkg::PTR_W-1:0]        m_src_reg_b,
    output logic                              m_src_a_renamed,
    output logic                              m_src_b_renamed,
    output logic [1:0]                        m_stack_slot,
    output logic [rprt_pkg::STACK_W-1:0]      m_stack_value
);
    import rprt_pkg::*;

    localparam int SLOT_W = $clog2(OP_SLOTS);

    rprt_cfg_t         cfg;
    rprt_status_t      status;
    rprt_op_t          q_op;
    logic [SLOT_W-1:0] q_slot;
    logic              q_valid;
    logic              pop;

    rprt_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rprt_front #(
        .OP_SLOTS (OP_SLOTS)
    ) u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_req_type          (s_req_type),
        .s_op_slot           (s_op_slot),
        .s_is_rpinc          (s_is_rpinc),
        .s_is_sp_add         (s_is_sp_add),
        .s_is_sp_mem         (s_is_sp_mem),
        .s_is_syscall_branch (s_is_syscall_branch),
        .s_three_imms        (s_three_imms),
        .s_immediate         (s_immediate),
        .s_source_count      (s_source_count),
        .s_distance_a        (s_distance_a),
        .s_distance_b        (s_distance_b),
        .pop                 (pop),
        .q_valid             (q_valid),
        .q_op                (q_op),
        .q_slot              (q_slot)
    );

    rprt_back #(
        .OP_SLOTS (OP_SLOTS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_op            (q_op),
        .q_slot          (q_slot),
        .pop             (pop),
        .cfg             (cfg),
        .status          (status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_dest_reg      (m_dest_reg),
        .m_src_reg_a     (m_src_reg_a),
        .m_src_reg_b     (m_src_reg_b),
        .m_src_a_renamed (m_src_a_renamed),
        .m_src_b_renamed (m_src_b_renamed),
        .m_stack_slot    (m_stack_slot),
        .m_stack_value   (m_stack_value)
    );

    a_no_pop_restore: assert property (@(posedge aclk) disable iff (!aresetn)
        status.restoring |-> !pop)
        else $error("Queue popped while checkpoint restore is pending.");

    a_restore_single: assert property (@(posedge aclk) disable iff (!aresetn)
        status.restoring |=> !status.restoring)
        else $error("Checkpoint restore lasted more than one cycle.");

    a_flush_enters_restore: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && q_op.is_flush |=> status.restoring)
        else $error("Flush transaction did not start a checkpoint restore.");

    a_no_inject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_stack_slot == STK_NONE) |-> (m_stack_value == '0))
        else $error("Stack value is nonzero without an injection slot.");

endmodule

[bench/tb_register_pointer_rename_tracker.sv]
// ============================================================================
// tb_register_pointer_rename_tracker: self-checking bench for the rename tracker
// Sends fetch and flush transactions on the input channel while both sides
// idle at random. Each transaction is predicted when it is accepted. Each result
// is checked field by field, oldest first. Start values are written over the
// APB-style port only when the block is idle, at their extremes and at random.
// ============================================================================
module tb_register_pointer_rename_tracker;

    import rprt_pkg::*;

    localparam int unsigned LIMIT_CYCLES     = 500000;
    localparam int          RANDOM_SEGMENTS  = 8;
    localparam int          SEGMENT_ITEMS    = 250;

    localparam logic [APB_AW-1:0] ADDR_START_POINTER = APB_AW'(REG_START_POINTER) << 3;
    localparam logic [APB_AW-1:0] ADDR_START_STACK   = APB_AW'(REG_START_STACK) << 3;

    localparam logic [4:0] OPF_NONE       = 5'b00000;
    localparam logic [4:0] OPF_RPINC      = 5'b00001;
    localparam logic [4:0] OPF_SP_ADD     = 5'b00010;
    localparam logic [4:0] OPF_SP_MEM     = 5'b00100;
    localparam logic [4:0] OPF_SYSCALL    = 5'b01000;
    localparam logic [4:0] OPF_THREE_IMMS = 5'b10000;

    typedef struct packed {
        logic                    req_type;
        logic [SLOT_IN_W-1:0]    op_slot;
        logic                    is_rpinc;
        logic                    is_sp_add;
        logic                    is_sp_mem;
        logic                    is_syscall_branch;
        logic                    three_imms;
        logic signed [IMM_W-1:0] immediate;
        logic [1:0]              source_count;
        logic [PTR_W-1:0]        distance_a;
        logic [PTR_W-1:0]        distance_b;
    } rename_req_t;

    typedef struct packed {
        logic [PTR_W-1:0]   dest_reg;
        logic [PTR_W-1:0]   src_reg_a;
        logic [PTR_W-1:0]   src_reg_b;
        logic               src_a_renamed;
        logic               src_b_renamed;
        logic [1:0]         stack_slot;
        logic [STACK_W-1:0] stack_value;
    } rename_res_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [APB_AW-1:0]       paddr = '0;
    logic [APB_DW-1:0]       pwdata = '0;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic                    s_req_type = REQ_FETCH;
    logic [SLOT_IN_W-1:0]    s_op_slot = '0;
    logic                    s_is_rpinc = 1'b0;
    logic                    s_is_sp_add = 1'b0;
    logic                    s_is_sp_mem = 1'b0;
    logic                    s_is_syscall_branch = 1'b0;
    logic                    s_three_imms = 1'b0;
    logic signed [IMM_W-1:0] s_immediate = '0;
    logic [1:0]              s_source_count = '0;
    logic [PTR_W-1:0]        s_distance_a = '0;
    logic [PTR_W-1:0]        s_distance_b = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [PTR_W-1:0]        m_dest_reg;
    logic [PTR_W-1:0]        m_src_reg_a;
    logic [PTR_W-1:0]        m_src_reg_b;
    logic                    m_src_a_renamed;
    logic                    m_src_b_renamed;
    logic [1:0]              m_stack_slot;
    logic [STACK_W-1:0]      m_stack_value;

    logic [PTR_W-1:0]   ring_ptr = '0;
    logic [STACK_W-1:0] stack_ptr = '0;
    logic [PTR_W-1:0]   ptr_checkpoint [OP_SLOTS_DEF];
    logic [STACK_W-1:0] stack_checkpoint [OP_SLOTS_DEF];
    bit                 slot_written [OP_SLOTS_DEF];
    logic [SLOT_IN_W-1:0] written_slots [$];

    rename_res_t expected_renames [$];
    rename_res_t head_rename;

    bit          send_gaps = 1'b1;
    bit          recv_stalls = 1'b1;
    int unsigned ready_hold = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned results_checked = 0;
    int unsigned fetch_count = 0;
    int unsigned flush_count = 0;
    int unsigned register_writes = 0;

    register_pointer_rename_tracker DUT (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_req_type          (s_req_type),
        .s_op_slot           (s_op_slot),
        .s_is_rpinc          (s_is_rpinc),
        .s_is_sp_add         (s_is_sp_add),
        .s_is_sp_mem         (s_is_sp_mem),
        .s_is_syscall_branch (s_is_syscall_branch),
        .s_three_imms        (s_three_imms),
        .s_immediate         (s_immediate),
        .s_source_count      (s_source_count),
        .s_distance_a        (s_distance_a),
        .s_distance_b        (s_distance_b),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_dest_reg          (m_dest_reg),
        .m_src_reg_a         (m_src_reg_a),
        .m_src_reg_b         (m_src_reg_b),
        .m_src_a_renamed     (m_src_a_renamed),
        .m_src_b_renamed     (m_src_b_renamed),
        .m_stack_slot        (m_stack_slot),
        .m_stack_value       (m_stack_value)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int unsigned idle_length(input bit enable);
        int unsigned pick;
        if (!enable) begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            return 0;
        end else if (pick < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
            m_ready <= 1'b0;
        end else if (recv_stalls && $urandom_range(0, 3) == 0) begin
            ready_hold = idle_length(1'b1);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic rename_res_t rename_predict(input rename_req_t item);
        rename_res_t res;
        int unsigned used;
        res = '0;
        if (item.req_type == REQ_FLUSH) begin
            ring_ptr  = ptr_checkpoint[item.op_slot];
            stack_ptr = stack_checkpoint[item.op_slot];
            return res;
        end
        used = (item.source_count > 2) ? 2 : item.source_count;
        res.dest_reg = ring_ptr;
        if (used >= 1 && item.distance_a != ZERO_DISTANCE) begin
            res.src_reg_a     = ring_ptr - item.distance_a;
            res.src_a_renamed = 1'b1;
        end
        if (used >= 2 && item.distance_b != ZERO_DISTANCE) begin
            res.src_reg_b     = ring_ptr - item.distance_b;
            res.src_b_renamed = 1'b1;
        end
        ptr_checkpoint[item.op_slot]   = ring_ptr;
        stack_checkpoint[item.op_slot] = stack_ptr;
        if (!slot_written[item.op_slot]) begin
            slot_written[item.op_slot] = 1'b1;
            written_slots.push_back(item.op_slot);
        end
        if (item.is_syscall_branch) begin
            return res;
        end
        if (item.is_rpinc) begin
            ring_ptr = ring_ptr + item.immediate[PTR_W-1:0] + 7'd1;
        end else begin
            ring_ptr = ring_ptr + 7'd1;
        end
        if (item.is_sp_add) begin
            stack_ptr = stack_ptr + {{(STACK_W-IMM_W){item.immediate[IMM_W-1]}}, item.immediate};
        end else if (item.is_sp_mem) begin
            res.stack_slot  = item.three_imms ? STK_IMM2 : STK_IMM1;
            res.stack_value = stack_ptr;
        end
        return res;
    endfunction

    function automatic rename_req_t fetch_op(input logic [SLOT_IN_W-1:0] slot,
                                             input logic [4:0] flags,
                                             input logic signed [IMM_W-1:0] imm,
                                             input logic [1:0] count,
                                             input logic [PTR_W-1:0] dist_a,
                                             input logic [PTR_W-1:0] dist_b);
        rename_req_t item;
        item.req_type          = REQ_FETCH;
        item.op_slot           = slot;
        item.is_rpinc          = (flags & OPF_RPINC) != 0;
        item.is_sp_add         = (flags & OPF_SP_ADD) != 0;
        item.is_sp_mem         = (flags & OPF_SP_MEM) != 0;
        item.is_syscall_branch = (flags & OPF_SYSCALL) != 0;
        item.three_imms        = (flags & OPF_THREE_IMMS) != 0;
        item.immediate         = imm;
        item.source_count      = count;
        item.distance_a        = dist_a;
        item.distance_b        = dist_b;
        return item;
    endfunction

    function automatic logic [PTR_W-1:0] random_distance();
        if ($urandom_range(0, 7) == 0) begin
            return ZERO_DISTANCE;
        end
        return PTR_W'($urandom_range(0, 127));
    endfunction

    function automatic rename_req_t random_fetch();
        rename_req_t item;
        int unsigned pick;
        int          small_imm;
        item.req_type          = REQ_FETCH;
        item.op_slot           = SLOT_IN_W'($urandom_range(0, OP_SLOTS_DEF - 1));
        item.is_rpinc          = ($urandom_range(0, 5) == 0);
        item.is_sp_add         = ($urandom_range(0, 4) == 0);
        item.is_sp_mem         = ($urandom_range(0, 3) == 0);
        item.is_syscall_branch = ($urandom_range(0, 9) == 0);
        item.three_imms        = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        small_imm = $urandom_range(0, 32);
        if (pick < 50) begin
            item.immediate = small_imm - 16;
        end else if (pick < 85) begin
            item.immediate = $urandom;
        end else begin
            case ($urandom_range(0, 3))
                0: item.immediate = 32'sh7FFF_FFFF;
                1: item.immediate = 32'sh8000_0000;
                2: item.immediate = -1;
                default: item.immediate = 0;
            endcase
        end
        item.source_count = 2'($urandom_range(0, 3));
        item.distance_a   = random_distance();
        item.distance_b   = random_distance();
        return item;
    endfunction

    function automatic rename_req_t flush_op(input logic [SLOT_IN_W-1:0] slot);
        rename_req_t item;
        item          = random_fetch();
        item.req_type = REQ_FLUSH;
        item.op_slot  = slot;
        return item;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[cycle %0d] %s", cycle_count, msg);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_renames.size() == 0) begin
                report_mismatch("result transaction with no expected result waiting");
            end else begin
                head_rename = expected_renames.pop_front();
                results_checked++;
                if (m_dest_reg !== head_rename.dest_reg)
                    report_mismatch($sformatf("dest_reg got %0d want %0d",
                                              m_dest_reg, head_rename.dest_reg));
                if (m_src_reg_a !== head_rename.src_reg_a)
                    report_mismatch($sformatf("src_reg_a got %0d want %0d",
                                              m_src_reg_a, head_rename.src_reg_a));
                if (m_src_reg_b !== head_rename.src_reg_b)
                    report_mismatch($sformatf("src_reg_b got %0d want %0d",
                                              m_src_reg_b, head_rename.src_reg_b));
                if (m_src_a_renamed !== head_rename.src_a_renamed)
                    report_mismatch($sformatf("src_a_renamed got %0b want %0b",
                                              m_src_a_renamed, head_rename.src_a_renamed));
                if (m_src_b_renamed !== head_rename.src_b_renamed)
                    report_mismatch($sformatf("src_b_renamed got %0b want %0b",
                                              m_src_b_renamed, head_rename.src_b_renamed));
                if (m_stack_slot !== head_rename.stack_slot)
                    report_mismatch($sformatf("stack_slot got %0d want %0d",
                                              m_stack_slot, head_rename.stack_slot));
                if (m_stack_value !== head_rename.stack_value)
                    report_mismatch($sformatf("stack_value got %h want %h",
                                              m_stack_value, head_rename.stack_value));
            end
        end
    end

    task automatic send_item(input rename_req_t item);
        int unsigned gap;
        gap = idle_length(send_gaps);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_req_type          <= item.req_type;
        s_op_slot           <= item.op_slot;
        s_is_rpinc          <= item.is_rpinc;
        s_is_sp_add         <= item.is_sp_add;
        s_is_sp_mem         <= item.is_sp_mem;
        s_is_syscall_branch <= item.is_syscall_branch;
        s_three_imms        <= item.three_imms;
        s_immediate         <= item.immediate;
        s_source_count      <= item.source_count;
        s_distance_a        <= item.distance_a;
        s_distance_b        <= item.distance_b;
        s_valid             <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        expected_renames.push_back(rename_predict(item));
        if (item.req_type == REQ_FLUSH) begin
            flush_count++;
        end else begin
            fetch_count++;
        end
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_renames.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_START_POINTER) begin
            ring_ptr = value[PTR_W-1:0];
        end else if (addr == ADDR_START_STACK) begin
            stack_ptr = value[STACK_W-1:0];
        end
        register_writes++;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic test_start_values();
        write_register(ADDR_START_POINTER, 64'd127);
        write_register(ADDR_START_STACK, '1);
        send_item(fetch_op(6'd1, OPF_SP_MEM, 0, 2'd2, 7'd1, 7'd127));
        send_item(fetch_op(6'd2, OPF_SP_ADD, 1, 2'd1, 7'd127, 7'd0));
        send_item(fetch_op(6'd3, OPF_SP_MEM | OPF_THREE_IMMS, 0, 2'd0, 7'd0, 7'd0));
        drain_results();
        write_register(ADDR_START_POINTER, 64'd0);
        write_register(ADDR_START_STACK, 64'd0);
    endtask

    task automatic test_rename_operands();
        send_item(fetch_op(6'd4, OPF_NONE, 0, 2'd0, 7'd9, 7'd9));
        send_item(fetch_op(6'd5, OPF_NONE, 0, 2'd3, 7'd5, 7'd6));
        send_item(fetch_op(6'd6, OPF_NONE, 0, 2'd2, ZERO_DISTANCE, ZERO_DISTANCE));
        send_item(fetch_op(6'd7, OPF_NONE, 0, 2'd1, 7'd127, 7'd3));
        send_item(fetch_op(6'd8, OPF_NONE, 0, 2'd2, ZERO_DISTANCE, 7'd127));
        drain_results();
    endtask

    task automatic test_pointer_updates();
        send_item(fetch_op(6'd63, OPF_RPINC, 32'sh7FFF_FFFF, 2'd2, 7'd1, 7'd2));
        send_item(fetch_op(6'd9, OPF_RPINC, 32'sh8000_0000, 2'd2, 7'd3, 7'd4));
        send_item(fetch_op(6'd10, OPF_RPINC, -1, 2'd1, 7'd1, 7'd0));
        send_item(fetch_op(6'd11, OPF_SP_ADD, 32'sh8000_0000, 2'd0, 7'd0, 7'd0));
        send_item(fetch_op(6'd12, OPF_SP_ADD, 32'sh7FFF_FFFF, 2'd0, 7'd0, 7'd0));
        send_item(fetch_op(6'd13, OPF_SP_ADD | OPF_SP_MEM, 5, 2'd1, 7'd2, 7'd0));
        send_item(fetch_op(6'd14, OPF_SYSCALL | OPF_SP_MEM | OPF_RPINC, 40, 2'd2, 7'd1, 7'd1));
        send_item(fetch_op(6'd15, OPF_SP_MEM, 0, 2'd2, 7'd64, 7'd63));
        send_item(fetch_op(6'd16, OPF_RPINC | OPF_SP_MEM | OPF_THREE_IMMS, 3, 2'd1, 7'd8, 7'd0));
        drain_results();
    endtask

    task automatic test_checkpoint_flush();
        send_item(flush_op(6'd63));
        send_item(fetch_op(6'd17, OPF_SP_MEM, 0, 2'd2, 7'd1, 7'd2));
        send_item(flush_op(6'd12));
        send_item(flush_op(6'd1));
        send_item(fetch_op(6'd18, OPF_SP_MEM | OPF_THREE_IMMS, 0, 2'd2, 7'd1, 7'd1));
        drain_results();
    endtask

    task automatic test_random_traffic();
        rename_req_t item;
        int          seg;
        int          k;
        for (seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
            send_gaps   = (seg % 4 == 1) || (seg % 4 == 3);
            recv_stalls = (seg % 4 >= 2);
            if (seg == RANDOM_SEGMENTS / 2) begin
                write_register(ADDR_START_POINTER, 64'($urandom_range(0, 127)));
                write_register(ADDR_START_STACK, {32'($urandom), 32'($urandom)});
            end
            for (k = 0; k < SEGMENT_ITEMS; k++) begin
                if (written_slots.size() != 0 && $urandom_range(0, 7) == 0) begin
                    item = flush_op(written_slots[$urandom_range(0, written_slots.size() - 1)]);
                end else begin
                    item = random_fetch();
                end
                send_item(item);
            end
            drain_results();
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_start_values();
        test_rename_operands();
        test_pointer_updates();
        test_checkpoint_flush();
        test_random_traffic();
        repeat (10) @(posedge aclk);
        $display("Sent %0d fetch and %0d flush transactions with %0d register writes in %0d cycles.",
                 fetch_count, flush_count, register_writes, cycle_count);
        $display("Compared %0d result transactions field by field.", results_checked);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
